// ----- rtl/plcil_pkg.sv -----
// shared types and constants of the instruction-list stack executor
package plcil_pkg;

  localparam int CMD_W     = 5;
  localparam int OPERAND_W = 16;
  localparam int VALUE_W   = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_LD   = 5'd0,
    CMD_LDN  = 5'd1,
    CMD_ST   = 5'd2,
    CMD_STN  = 5'd3,
    CMD_AND  = 5'd4,
    CMD_ANDN = 5'd5,
    CMD_OR   = 5'd6,
    CMD_ORN  = 5'd7,
    CMD_XOR  = 5'd8,
    CMD_XORN = 5'd9,
    CMD_ADD  = 5'd10,
    CMD_SUB  = 5'd11,
    CMD_MUL  = 5'd12,
    CMD_DIV  = 5'd13,
    CMD_GT   = 5'd14,
    CMD_LT   = 5'd15,
    CMD_GE   = 5'd16,
    CMD_LE   = 5'd17,
    CMD_S    = 5'd18,
    CMD_R    = 5'd19,
    CMD_SWP  = 5'd20,
    CMD_DUP  = 5'd21
  } cmd_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } md_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md_rsp_t;

endpackage

// ----- rtl/plcil_if.sv -----
// valid/ready channel interfaces for instructions and results
interface plcil_in_if;
  logic                              valid;
  logic                              ready;
  logic [plcil_pkg::CMD_W-1:0]       cmd;
  logic signed [plcil_pkg::OPERAND_W-1:0] operand;
  logic                              stack_form;

  modport source (output valid, cmd, operand, stack_form, input ready);
  modport sink (input valid, cmd, operand, stack_form, output ready);
endinterface

interface plcil_out_if #(parameter int DEPTH_W = 6);
  logic                                 valid;
  logic                                 ready;
  logic                                 write_enable;
  logic signed [plcil_pkg::VALUE_W-1:0] write_value;
  logic signed [plcil_pkg::VALUE_W-1:0] top_value;
  logic [DEPTH_W-1:0]                   depth;
  logic                                 underflow;
  logic                                 overflow;
  logic                                 divide_by_zero;

  modport source (output valid, write_enable, write_value, top_value, depth,
                  underflow, overflow, divide_by_zero, input ready);
  modport sink (input valid, write_enable, write_value, top_value, depth,
                underflow, overflow, divide_by_zero, output ready);
endinterface

// ----- rtl/plcil_ram.sv -----
// generic single-port-write ram with registered read
module plcil_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ----- rtl/plcil_muldiv.sv -----
// iterative shift-add multiplier and restoring divider, one bit per cycle
module plcil_muldiv #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  plcil_pkg::md_req_t           req,
  input  logic signed [DATA_WIDTH-1:0] a,
  input  logic signed [DATA_WIDTH-1:0] b,
  output plcil_pkg::md_rsp_t           rsp,
  output logic [DATA_WIDTH-1:0]        result
);
  localparam int CW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

  logic                  busy;
  logic                  done;
  logic                  is_div;
  logic                  neg;
  logic [CW-1:0]         cnt;
  logic [DATA_WIDTH-1:0] acc;
  logic [DATA_WIDTH-1:0] x;
  logic [DATA_WIDTH-1:0] y;
  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH-1:0] a_mag;
  logic [DATA_WIDTH-1:0] b_mag;

  assign a_mag = a[DATA_WIDTH-1] ? -a : a;
  assign b_mag = b[DATA_WIDTH-1] ? -b : b;
  assign trial = {acc, x[DATA_WIDTH-1]} - {1'b0, y};

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign result   = is_div ? (neg ? -x : x) : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy   <= 1'b1;
        is_div <= req.is_div;
        cnt    <= CW'(DATA_WIDTH - 1);
        acc    <= '0;
        if (req.is_div) begin
          x   <= a_mag;
          y   <= b_mag;
          neg <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
        end else begin
          x   <= a;
          y   <= b;
          neg <= 1'b0;
        end
      end else if (busy) begin
        if (is_div) begin
          if (!trial[DATA_WIDTH]) begin
            acc <= trial[DATA_WIDTH-1:0];
            x   <= {x[DATA_WIDTH-2:0], 1'b1};
          end else begin
            acc <= {acc[DATA_WIDTH-2:0], x[DATA_WIDTH-1]};
            x   <= {x[DATA_WIDTH-2:0], 1'b0};
          end
        end else begin
          if (y[0]) begin
            acc <= acc + x;
          end
          x <= {x[DATA_WIDTH-2:0], 1'b0};
          y <= {1'b0, y[DATA_WIDTH-1:1]};
        end
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end
endmodule

// ----- rtl/plc_il_stack_executor.sv -----
// top level of the instruction-list stack executor
// Usage:
//   in_ch carries one instruction per transaction (cmd, operand, stack_form);
//   out_ch returns exactly one result per instruction, in order.
//   ready on in_ch is high only while the sequencer is idle; one instruction
//   is worked at a time.
// Steps, accept to result valid:
//   most instructions go through execute, then commit to the stack ram;
//   SWP does the same, and its second ram write follows the result;
//   MUL and DIV by nonzero wait between execute and commit for the
//   one-bit-per-cycle shared multiply/divide unit.
// A new instruction is accepted only after the previous one leaves commit,
//   or for SWP after its second ram write.
// Stack entries live in a ram; the top entry is also held in a register, and
//   the entry below it is read ahead so both operands are ready in execute.
// Reset empties the stack (depth 0, top reads -1) and drops any result.
// A result waits in the output register while out_ch stalls; a following
//   instruction is accepted and holds in its commit step until the slot frees.
module plc_il_stack_executor #(
  parameter int STACK_DEPTH = 32,
  parameter int DATA_WIDTH  = 16
) (
  input logic          clk,
  input logic          rst,
  plcil_in_if.sink     in_ch,
  plcil_out_if.source  out_ch
);
  localparam int IW = $clog2(STACK_DEPTH);
  localparam int SW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_MD, S_COMMIT, S_SWP2} state_t;

  state_t                         state;
  logic [plcil_pkg::CMD_W-1:0]    cmd_q;
  logic signed [plcil_pkg::OPERAND_W-1:0] operand_q;
  logic                           sf_q;
  logic [SW-1:0]                  sp;
  logic signed [DATA_WIDTH-1:0]   top_q;
  logic signed [DATA_WIDTH-1:0]   second_q;
  logic signed [DATA_WIDTH-1:0]   res_q;
  logic [SW-1:0]                  sp_pop_q;
  logic                           push_q;
  logic                           pop_q;
  logic                           swp_q;
  logic                           uf_q;
  logic                           dz_q;
  logic                           we_q;
  logic signed [DATA_WIDTH-1:0]   wv_q;
  logic                           out_valid;
  plcil_pkg::md_req_t             md_req;
  plcil_pkg::md_rsp_t             md_rsp;
  logic [DATA_WIDTH-1:0]          md_result;

  logic [DATA_WIDTH-1:0]          rd_data;
  logic                           ram_we;
  logic [SW-1:0]                  ram_waddr_full;
  logic [DATA_WIDTH-1:0]          ram_wdata;
  logic [SW-1:0]                  sp_m1;
  logic [SW-1:0]                  sp_m2;

  logic                           sp_ge1;
  logic                           sp_ge2;
  logic signed [DATA_WIDTH-1:0]   opv;
  logic signed [DATA_WIDTH-1:0]   second;
  logic signed [DATA_WIDTH-1:0]   a_v;
  logic signed [DATA_WIDTH-1:0]   b_v;
  logic                           binary;
  logic                           two_pop;
  logic signed [DATA_WIDTH-1:0]   r_v;
  logic                           slot_free;
  logic                           push_ok;
  logic [SW-1:0]                  sp_new;
  logic signed [DATA_WIDTH-1:0]   top_new;

  assign sp_m1  = sp - 1'b1;
  assign sp_m2  = sp - SW'(2);
  assign sp_ge1 = (sp != '0);
  assign sp_ge2 = (sp > SW'(1));
  assign opv    = DATA_WIDTH'(operand_q);
  assign second = sp_ge2 ? signed'(rd_data) : '1;
  assign a_v    = sp_ge1 ? top_q : '1;

  always_comb begin
    binary = 1'b0;
    case (cmd_q)
      plcil_pkg::CMD_AND, plcil_pkg::CMD_OR, plcil_pkg::CMD_XOR,
      plcil_pkg::CMD_XORN, plcil_pkg::CMD_ADD, plcil_pkg::CMD_SUB,
      plcil_pkg::CMD_MUL, plcil_pkg::CMD_DIV, plcil_pkg::CMD_GT,
      plcil_pkg::CMD_LT, plcil_pkg::CMD_GE, plcil_pkg::CMD_LE: binary = 1'b1;
      default: binary = 1'b0;
    endcase
  end

  assign two_pop = binary && sf_q;
  assign b_v     = two_pop ? second : opv;

  always_comb begin
    case (cmd_q)
      plcil_pkg::CMD_AND:  r_v = DATA_WIDTH'(a_v != '0 && b_v != '0);
      plcil_pkg::CMD_OR:   r_v = DATA_WIDTH'(a_v != '0 || b_v != '0);
      plcil_pkg::CMD_XOR:  r_v = DATA_WIDTH'(a_v != b_v);
      plcil_pkg::CMD_XORN: r_v = DATA_WIDTH'(a_v == b_v);
      plcil_pkg::CMD_ADD:  r_v = a_v + b_v;
      plcil_pkg::CMD_SUB:  r_v = a_v - b_v;
      plcil_pkg::CMD_GT:   r_v = DATA_WIDTH'(a_v > b_v);
      plcil_pkg::CMD_LT:   r_v = DATA_WIDTH'(a_v < b_v);
      plcil_pkg::CMD_GE:   r_v = DATA_WIDTH'(a_v >= b_v);
      plcil_pkg::CMD_LE:   r_v = DATA_WIDTH'(a_v <= b_v);
      plcil_pkg::CMD_ANDN: r_v = DATA_WIDTH'(a_v != '0 && opv == '0);
      plcil_pkg::CMD_ORN:  r_v = DATA_WIDTH'(a_v != '0 || opv == '0);
      plcil_pkg::CMD_LD:   r_v = opv;
      plcil_pkg::CMD_LDN:  r_v = DATA_WIDTH'(opv == '0);
      plcil_pkg::CMD_DUP:  r_v = top_q;
      plcil_pkg::CMD_SWP:  r_v = top_q;
      default:             r_v = '0;
    endcase
  end

  assign slot_free = !out_valid || out_ch.ready;
  assign push_ok   = push_q && (sp_pop_q != SW'(STACK_DEPTH));
  assign sp_new    = push_ok ? sp_pop_q + 1'b1 : sp_pop_q;
  assign top_new   = swp_q ? second_q : (push_ok ? res_q : (pop_q ? second_q : top_q));

  always_comb begin
    ram_we         = 1'b0;
    ram_waddr_full = sp_pop_q;
    ram_wdata      = res_q;
    if (state == S_COMMIT && slot_free && (push_ok || swp_q)) begin
      ram_we = 1'b1;
      if (swp_q) begin
        ram_waddr_full = sp_m1;
        ram_wdata      = second_q;
      end
    end else if (state == S_SWP2) begin
      ram_we         = 1'b1;
      ram_waddr_full = sp_m2;
    end
  end

  plcil_ram #(.WIDTH(DATA_WIDTH), .DEPTH(STACK_DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr_full[IW-1:0]),
    .wr_data (ram_wdata),
    .rd_addr (sp_m2[IW-1:0]),
    .rd_data (rd_data)
  );

  plcil_muldiv #(.DATA_WIDTH(DATA_WIDTH)) u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .req    (md_req),
    .a      (a_v),
    .b      (b_v),
    .rsp    (md_rsp),
    .result (md_result)
  );

  assign in_ch.ready  = (state == S_IDLE);
  assign out_ch.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sp           <= '0;
      out_valid    <= 1'b0;
      md_req.start <= 1'b0;
    end else begin
      md_req.start <= 1'b0;
      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            cmd_q     <= in_ch.cmd;
            operand_q <= in_ch.operand;
            sf_q      <= in_ch.stack_form;
            state     <= S_EXEC;
          end
        end
        S_EXEC: begin
          second_q <= second;
          res_q    <= r_v;
          dz_q     <= 1'b0;
          we_q     <= 1'b0;
          wv_q     <= '0;
          push_q   <= 1'b0;
          pop_q    <= 1'b0;
          swp_q    <= 1'b0;
          uf_q     <= 1'b0;
          sp_pop_q <= sp;
          state    <= S_COMMIT;
          if (binary) begin
            push_q <= 1'b1;
            pop_q  <= 1'b1;
            if (two_pop) begin
              uf_q     <= !sp_ge2;
              sp_pop_q <= sp_ge2 ? sp_m2 : '0;
            end else begin
              uf_q     <= !sp_ge1;
              sp_pop_q <= sp_ge1 ? sp_m1 : '0;
            end
            if (cmd_q == plcil_pkg::CMD_MUL ||
                (cmd_q == plcil_pkg::CMD_DIV && b_v != '0)) begin
              md_req.start  <= 1'b1;
              md_req.is_div <= (cmd_q == plcil_pkg::CMD_DIV);
              state         <= S_MD;
            end else if (cmd_q == plcil_pkg::CMD_DIV) begin
              dz_q  <= 1'b1;
              res_q <= '0;
            end
          end else begin
            case (cmd_q)
              plcil_pkg::CMD_LD, plcil_pkg::CMD_LDN: push_q <= 1'b1;
              plcil_pkg::CMD_ANDN, plcil_pkg::CMD_ORN: begin
                push_q   <= 1'b1;
                pop_q    <= 1'b1;
                uf_q     <= !sp_ge1;
                sp_pop_q <= sp_ge1 ? sp_m1 : '0;
              end
              plcil_pkg::CMD_ST, plcil_pkg::CMD_STN,
              plcil_pkg::CMD_S, plcil_pkg::CMD_R: begin
                pop_q    <= 1'b1;
                uf_q     <= !sp_ge1;
                sp_pop_q <= sp_ge1 ? sp_m1 : '0;
                if (cmd_q == plcil_pkg::CMD_ST) begin
                  we_q <= 1'b1;
                  wv_q <= a_v;
                end else if (cmd_q == plcil_pkg::CMD_STN) begin
                  we_q <= 1'b1;
                  wv_q <= DATA_WIDTH'(a_v == '0);
                end else begin
                  we_q <= (a_v != '0);
                  wv_q <= (a_v != '0 && cmd_q == plcil_pkg::CMD_S) ? DATA_WIDTH'(1) : '0;
                end
              end
              plcil_pkg::CMD_SWP: swp_q  <= sp_ge2;
              plcil_pkg::CMD_DUP: push_q <= sp_ge1;
              default: push_q <= 1'b0;
            endcase
          end
        end
        S_MD: begin
          if (md_rsp.done) begin
            res_q <= signed'(md_result);
            state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (slot_free) begin
            sp                    <= sp_new;
            top_q                 <= top_new;
            out_valid             <= 1'b1;
            out_ch.write_enable   <= we_q;
            out_ch.write_value    <= plcil_pkg::VALUE_W'(wv_q);
            out_ch.top_value      <= (sp_new != '0) ? plcil_pkg::VALUE_W'(top_new) : '1;
            out_ch.depth          <= sp_new;
            out_ch.underflow      <= uf_q;
            out_ch.overflow       <= push_q && !push_ok;
            out_ch.divide_by_zero <= dz_q;
            state                 <= swp_q ? S_SWP2 : S_IDLE;
          end
        end
        S_SWP2: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.depth <= SW'(STACK_DEPTH))
    else $error("result depth beyond stack size");
  a_empty_top: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.depth == '0 |-> out_ch.top_value == '1)
    else $error("empty stack must report top of -1");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("accepted a transaction while executing");
  a_dz_flags: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.divide_by_zero |-> !out_ch.write_enable && !out_ch.overflow)
    else $error("divide by zero with write or overflow");
`endif
endmodule
